/* src/ray_plane_intersect_core_assert.svh */
// ----------------------------------------------------------------------------
// ray plane intersect core assertion macros
// concurrent checks on clk_i with reset disable, reported through $error
// ----------------------------------------------------------------------------
`ifndef RAY_PLANE_INTERSECT_CORE_ASSERT_SVH
`define RAY_PLANE_INTERSECT_CORE_ASSERT_SVH

// same-cycle implication
`define RPI_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rpi check failed");

// next-cycle implication
`define RPI_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rpi check failed");

`endif

/* src/rpi_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_pkg
// shared constants, types and the divider step for the ray plane intersect core
// ----------------------------------------------------------------------------
package rpi_pkg;

  localparam int FracBits  = 16;
  localparam int CoordW    = 32;
  localparam int ThrW      = 17;
  localparam int DenW      = 64;
  localparam int NumW      = 97;
  localparam int QCapBits  = 40;
  localparam int QW        = QCapBits + 1;
  localparam int AddrW     = 5;
  localparam int DataW     = 32;
  localparam int FrontSt   = 10;
  localparam int DivSteps  = NumW;

  localparam logic [QW-1:0] QCap = {1'b1, {QCapBits{1'b0}}};

  typedef enum logic [1:0] {
    StatHit      = 2'd0,
    StatParallel = 2'd1,
    StatBehind   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    RegPtX  = 3'd0,
    RegPtY  = 3'd1,
    RegPtZ  = 3'd2,
    RegNmX  = 3'd3,
    RegNmY  = 3'd4,
    RegNmZ  = 3'd5,
    RegThr  = 3'd6
  } reg_idx_e;

  typedef struct packed {
    logic [2:0][CoordW-1:0] pt;
    logic [2:0][CoordW-1:0] nm;
    logic [ThrW-1:0]        thr;
  } plane_cfg_t;

  typedef struct packed {
    status_e                status;
    logic [DenW-1:0]        den;
    logic [2:0][CoordW-1:0] org;
    logic [2:0]             neg;
    logic [2:0][NumW-1:0]   sh;
    logic [2:0][DenW-1:0]   rem;
  } div_item_t;

  localparam plane_cfg_t CfgRst = '{
    pt:  '0,
    nm:  {CoordW'(0), (CoordW'(1) << FracBits), CoordW'(0)},
    thr: ThrW'(1)
  };

  // one restoring step: returns {remainder, shifted numerator with quotient bit}
  function automatic logic [DenW+NumW-1:0] div_step(input logic [DenW-1:0] rem,
                                                     input logic [NumW-1:0] sh,
                                                     input logic [DenW-1:0] den);
    logic [DenW:0] nr;
    logic          qb;
    nr = {rem, sh[NumW-1]};
    qb = (nr >= {1'b0, den});
    if (qb) begin
      nr = nr - {1'b0, den};
    end
    return {nr[DenW-1:0], sh[NumW-2:0], qb};
  endfunction

endpackage

/* src/rpi_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_front
// dot products, exact parallel test, status and divider numerators
// ----------------------------------------------------------------------------
module rpi_front (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           en_i,
  input  logic                           valid_i,
  input  rpi_pkg::plane_cfg_t            cfg_i,
  input  logic [2:0][rpi_pkg::CoordW-1:0] org_i,
  input  logic [2:0][rpi_pkg::CoordW-1:0] dir_i,
  output logic                           valid_o,
  output rpi_pkg::div_item_t             item_o
);
  import rpi_pkg::*;

  localparam int CmpW = 192;

  logic [FrontSt-1:0]          vld_q;
  logic [2:0][CoordW-1:0]      org_q [1:FrontSt];
  logic [2:0][CoordW-1:0]      dir_q [1:8];
  logic signed [CoordW:0]      diff_q [3];
  logic signed [63:0]          pd_q [3];
  logic signed [64:0]          pn_q [3];
  logic signed [63:0]          nsq_q [3];
  logic signed [63:0]          dirsq_q [3];
  logic signed [65:0]          dot_d_q;
  logic signed [66:0]          dot_n_q;
  logic [63:0]                 nn_q;
  logic [63:0]                 dd_q;
  logic [33:0]                 thr2_q [3:5];
  logic [DenW-1:0]             dmag_q [4:FrontSt];
  logic [64:0]                 nmag_q [4:8];
  logic                        dneg_q [4:8];
  logic                        nneg_q [4:8];
  logic                        dzero_q [4:7];
  logic                        nzero_q [4:7];
  logic [3:0][63:0]            ndp_q;
  logic [127:0]                nd_q;
  logic [2:0][63:0]            dsp_q;
  logic [127:0]                dsq_q [6:7];
  logic [3:0][65:0]            rp_q;
  logic [161:0]                rhs_q;
  status_e                     status_q [8:FrontSt];
  logic [2:0][CoordW-1:0]      dirm_q;
  logic [2:0][63:0]            nlo_q;
  logic [2:0][64:0]            nhi_q;
  logic [2:0]                  neg_q [9:FrontSt];
  logic [2:0][NumW-1:0]        num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[FrontSt-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      // operand carry lines
      org_q[1] <= org_i;
      dir_q[1] <= dir_i;
      for (int s = 2; s <= FrontSt; s++) org_q[s] <= org_q[s-1];
      for (int s = 2; s <= 8; s++) dir_q[s] <= dir_q[s-1];
      for (int s = 5; s <= FrontSt; s++) dmag_q[s] <= dmag_q[s-1];
      for (int s = 5; s <= 8; s++) begin
        nmag_q[s]  <= nmag_q[s-1];
        dneg_q[s]  <= dneg_q[s-1];
        nneg_q[s]  <= nneg_q[s-1];
      end
      for (int s = 5; s <= 7; s++) begin
        dzero_q[s] <= dzero_q[s-1];
        nzero_q[s] <= nzero_q[s-1];
      end
      thr2_q[4]   <= thr2_q[3];
      thr2_q[5]   <= thr2_q[4];
      dsq_q[7]    <= dsq_q[6];
      status_q[9]  <= status_q[8];
      status_q[10] <= status_q[9];
      neg_q[10]   <= neg_q[9];

      // stage 1: point minus origin
      for (int k = 0; k < 3; k++) begin
        diff_q[k] <= 33'($signed(cfg_i.pt[k])) - 33'($signed(org_i[k]));
      end

      // stage 2: products
      for (int k = 0; k < 3; k++) begin
        pd_q[k]    <= $signed(cfg_i.nm[k]) * $signed(dir_q[1][k]);
        pn_q[k]    <= $signed(cfg_i.nm[k]) * diff_q[k];
        nsq_q[k]   <= $signed(cfg_i.nm[k]) * $signed(cfg_i.nm[k]);
        dirsq_q[k] <= $signed(dir_q[1][k]) * $signed(dir_q[1][k]);
      end

      // stage 3: sums
      dot_d_q   <= 66'(pd_q[0]) + 66'(pd_q[1]) + 66'(pd_q[2]);
      dot_n_q   <= 67'(pn_q[0]) + 67'(pn_q[1]) + 67'(pn_q[2]);
      nn_q      <= 64'(nsq_q[0]) + 64'(nsq_q[1]) + 64'(nsq_q[2]);
      dd_q      <= 64'(dirsq_q[0]) + 64'(dirsq_q[1]) + 64'(dirsq_q[2]);
      thr2_q[3] <= 34'(cfg_i.thr) * 34'(cfg_i.thr);

      // stage 4: magnitudes, length product partials
      dmag_q[4]  <= dot_d_q[65] ? 64'(-dot_d_q) : 64'(dot_d_q);
      nmag_q[4]  <= dot_n_q[66] ? 65'(-dot_n_q) : 65'(dot_n_q);
      dneg_q[4]  <= dot_d_q[65];
      nneg_q[4]  <= dot_n_q[66];
      dzero_q[4] <= (dot_d_q == '0);
      nzero_q[4] <= (dot_n_q == '0);
      ndp_q[0]   <= nn_q[31:0]  * dd_q[31:0];
      ndp_q[1]   <= nn_q[31:0]  * dd_q[63:32];
      ndp_q[2]   <= nn_q[63:32] * dd_q[31:0];
      ndp_q[3]   <= nn_q[63:32] * dd_q[63:32];

      // stage 5: length product, dot square partials
      nd_q     <= 128'(ndp_q[0]) + (128'(ndp_q[1]) << 32) + (128'(ndp_q[2]) << 32)
                + (128'(ndp_q[3]) << 64);
      dsp_q[0] <= dmag_q[4][31:0]  * dmag_q[4][31:0];
      dsp_q[1] <= dmag_q[4][31:0]  * dmag_q[4][63:32];
      dsp_q[2] <= dmag_q[4][63:32] * dmag_q[4][63:32];

      // stage 6: dot square, threshold partials
      dsq_q[6] <= 128'(dsp_q[0]) + (128'(dsp_q[1]) << 33) + (128'(dsp_q[2]) << 64);
      for (int k = 0; k < 4; k++) begin
        rp_q[k] <= 66'(nd_q[32*k +: 32]) * 66'(thr2_q[5]);
      end

      // stage 7: threshold side
      rhs_q <= 162'(rp_q[0]) + (162'(rp_q[1]) << 32) + (162'(rp_q[2]) << 64)
             + (162'(rp_q[3]) << 96);

      // stage 8: classify
      if (dzero_q[7]) begin
        status_q[8] <= StatParallel;
      end else if ((CmpW'(dsq_q[7]) << (2 * FracBits)) < CmpW'(rhs_q)) begin
        status_q[8] <= StatParallel;
      end else if (!nzero_q[7] && (nneg_q[7] != dneg_q[7])) begin
        status_q[8] <= StatBehind;
      end else begin
        status_q[8] <= StatHit;
      end
      for (int k = 0; k < 3; k++) begin
        dirm_q[k] <= dir_q[7][k][CoordW-1] ? CoordW'(-$signed(dir_q[7][k])) : dir_q[7][k];
      end

      // stage 9: numerator partials
      for (int k = 0; k < 3; k++) begin
        nlo_q[k]    <= 64'(dirm_q[k]) * 64'(nmag_q[8][31:0]);
        nhi_q[k]    <= 65'(dirm_q[k]) * 65'(nmag_q[8][64:32]);
        neg_q[9][k] <= dir_q[8][k][CoordW-1] ^ nneg_q[8] ^ dneg_q[8];
      end

      // stage 10: numerators
      for (int k = 0; k < 3; k++) begin
        num_q[k] <= 97'(nlo_q[k]) + (97'(nhi_q[k]) << 32);
      end
    end
  end

  assign valid_o       = vld_q[FrontSt-1];
  assign item_o.status = status_q[FrontSt];
  assign item_o.den    = dmag_q[FrontSt];
  assign item_o.org    = org_q[FrontSt];
  assign item_o.neg    = neg_q[FrontSt];
  assign item_o.sh     = num_q;
  assign item_o.rem    = '0;

endmodule

/* src/rpi_div_stage.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_div_stage
// one registered restoring division step for all three lanes
// ----------------------------------------------------------------------------
module rpi_div_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  rpi_pkg::div_item_t item_i,
  output logic               valid_o,
  output rpi_pkg::div_item_t item_o
);
  import rpi_pkg::*;

  logic      valid_q;
  div_item_t item_d;
  div_item_t item_q;

  always_comb begin
    item_d = item_i;
    for (int k = 0; k < 3; k++) begin
      {item_d.rem[k], item_d.sh[k]} = div_step(item_i.rem[k], item_i.sh[k], item_i.den);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      item_q <= item_d;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

/* src/rpi_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_div
// pipelined divider, one quotient bit per stage
// ----------------------------------------------------------------------------
module rpi_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  rpi_pkg::div_item_t item_i,
  output logic               valid_o,
  output rpi_pkg::div_item_t item_o
);
  import rpi_pkg::*;

  logic [DivSteps:0] vld;
  div_item_t         itm [0:DivSteps];

  assign vld[0] = valid_i;
  assign itm[0] = item_i;

  for (genvar g = 0; g < DivSteps; g++) begin : g_step
    rpi_div_stage u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en_i),
      .valid_i (vld[g]),
      .item_i  (itm[g]),
      .valid_o (vld[g+1]),
      .item_o  (itm[g+1])
    );
  end

  assign valid_o = vld[DivSteps];
  assign item_o  = itm[DivSteps];

endmodule

/* src/ray_plane_intersect_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ray_plane_intersect_core
// fixed point ray against plane intersection, unless stalled one ray per cycle
// ----------------------------------------------------------------------------
// the ray channel takes origin and direction on ray_valid_i; a transaction
// completes on an edge where ray_valid_i is high and ray_stall_o is low.
// each ray gives one result transaction on hit_valid_o / hit_stall_i with a
// status (hit, parallel, behind) and the saturated hit point, zero unless hit.
// the plane point, normal and parallel threshold live in registers on the
// apb port at byte addresses 0 to 24; program them while no ray is in flight.
// the datapath holds 108 register stages: ten arithmetic stages, a 97 stage
// divider and the output register.
// throughput: one ray per cycle while the result side does not stall.
// when a held result is stalled the whole pipeline freezes and ray_stall_o
// rises in the same cycle; nothing is lost or repeated.
// reset clears all stage valid bits and loads the plane registers with
// point zero, normal pointing up along y and threshold one lsb.
// ----------------------------------------------------------------------------
module ray_plane_intersect_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [rpi_pkg::AddrW-1:0]    paddr,
  input  logic [rpi_pkg::DataW-1:0]    pwdata,
  output logic [rpi_pkg::DataW-1:0]    prdata,
  output logic                         pready,
  input  logic                         ray_valid_i,
  output logic                         ray_stall_o,
  input  logic signed [31:0]           ray_origin_x_i,
  input  logic signed [31:0]           ray_origin_y_i,
  input  logic signed [31:0]           ray_origin_z_i,
  input  logic signed [31:0]           ray_dir_x_i,
  input  logic signed [31:0]           ray_dir_y_i,
  input  logic signed [31:0]           ray_dir_z_i,
  output logic                         hit_valid_o,
  input  logic                         hit_stall_i,
  output logic [1:0]                   hit_status_o,
  output logic signed [31:0]           hit_x_o,
  output logic signed [31:0]           hit_y_o,
  output logic signed [31:0]           hit_z_o
);
  import rpi_pkg::*;

  localparam int SumW = CoordW + 11;

  plane_cfg_t             cfg_q;
  logic                   cfg_wr;
  logic                   en;
  logic [2:0][CoordW-1:0] org;
  logic [2:0][CoordW-1:0] dir;
  logic                   fr_valid;
  div_item_t              fr_item;
  logic                   dv_valid;
  div_item_t              dv_item;
  logic [NumW-1:0]        quot [3];
  logic                   rnd [3];
  logic [QW-1:0]          qc [3];
  logic signed [SumW-1:0] sum [3];
  logic [2:0][CoordW-1:0] hit_d;
  logic [2:0][CoordW-1:0] hit_q;
  status_e                status_q;
  logic                   hit_valid_q;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgRst;
    end else if (cfg_wr) begin
      unique case (reg_idx_e'(paddr[4:2]))
        RegPtX:  cfg_q.pt[0] <= pwdata;
        RegPtY:  cfg_q.pt[1] <= pwdata;
        RegPtZ:  cfg_q.pt[2] <= pwdata;
        RegNmX:  cfg_q.nm[0] <= pwdata;
        RegNmY:  cfg_q.nm[1] <= pwdata;
        RegNmZ:  cfg_q.nm[2] <= pwdata;
        RegThr:  cfg_q.thr   <= pwdata[ThrW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_e'(paddr[4:2]))
      RegPtX:  prdata = cfg_q.pt[0];
      RegPtY:  prdata = cfg_q.pt[1];
      RegPtZ:  prdata = cfg_q.pt[2];
      RegNmX:  prdata = cfg_q.nm[0];
      RegNmY:  prdata = cfg_q.nm[1];
      RegNmZ:  prdata = cfg_q.nm[2];
      RegThr:  prdata = DataW'(cfg_q.thr);
      default: prdata = '0;
    endcase
  end

  // pipeline advance
  assign en          = !hit_valid_q || !hit_stall_i;
  assign ray_stall_o = !en;

  assign org = {ray_origin_z_i, ray_origin_y_i, ray_origin_x_i};
  assign dir = {ray_dir_z_i, ray_dir_y_i, ray_dir_x_i};

  rpi_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (ray_valid_i),
    .cfg_i   (cfg_q),
    .org_i   (org),
    .dir_i   (dir),
    .valid_o (fr_valid),
    .item_o  (fr_item)
  );

  rpi_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (fr_valid),
    .item_i  (fr_item),
    .valid_o (dv_valid),
    .item_o  (dv_item)
  );

  // rounding, offset add and saturation
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      quot[k] = dv_item.sh[k];
      rnd[k]  = ({dv_item.rem[k], 1'b0} >= {1'b0, dv_item.den});
      if (quot[k] >= NumW'(QCap)) begin
        qc[k] = QCap;
      end else begin
        qc[k] = quot[k][QW-1:0] + QW'(rnd[k]);
      end
      if (dv_item.neg[k]) begin
        sum[k] = SumW'($signed(dv_item.org[k])) - $signed(SumW'(qc[k]));
      end else begin
        sum[k] = SumW'($signed(dv_item.org[k])) + $signed(SumW'(qc[k]));
      end
      if (dv_item.status != StatHit) begin
        hit_d[k] = '0;
      end else if ((sum[k][SumW-1:CoordW-1] == '0) || (sum[k][SumW-1:CoordW-1] == '1)) begin
        hit_d[k] = sum[k][CoordW-1:0];
      end else if (sum[k][SumW-1]) begin
        hit_d[k] = {1'b1, {(CoordW-1){1'b0}}};
      end else begin
        hit_d[k] = {1'b0, {(CoordW-1){1'b1}}};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_valid_q <= 1'b0;
    end else if (en) begin
      hit_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      status_q <= dv_item.status;
      hit_q    <= hit_d;
    end
  end

  assign hit_valid_o  = hit_valid_q;
  assign hit_status_o = status_q;
  assign hit_x_o      = hit_q[0];
  assign hit_y_o      = hit_q[1];
  assign hit_z_o      = hit_q[2];

endmodule

/* src/rpi_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rpi_checker
// port level checks for the ray plane intersect core, bound to the top level
// ----------------------------------------------------------------------------
`include "ray_plane_intersect_core_assert.svh"

module rpi_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      ray_stall_o,
  input logic                      hit_valid_o,
  input logic                      hit_stall_i,
  input logic [1:0]                hit_status_o,
  input logic signed [31:0]        hit_x_o,
  input logic signed [31:0]        hit_y_o,
  input logic signed [31:0]        hit_z_o
);
  import rpi_pkg::*;

  // ray side only blocks when a finished transaction is held
  `RPI_ASSERT_IMP(a_stall_only_when_held, ray_stall_o, hit_valid_o && hit_stall_i)

  // misses carry a zero point
  `RPI_ASSERT_IMP(a_miss_zero, hit_valid_o && (hit_status_o != StatHit), (hit_x_o == '0) && (hit_y_o == '0) && (hit_z_o == '0))

  // a stalled result stays put
  `RPI_ASSERT_NXT(a_result_hold, hit_valid_o && hit_stall_i, hit_valid_o && $stable(hit_status_o) && $stable(hit_x_o) && $stable(hit_y_o) && $stable(hit_z_o))

endmodule

bind ray_plane_intersect_core rpi_checker u_rpi_checker (.*);
